/* src/sacl_pkg.sv */
// shared types, constants and helpers for the set-associative lru cache tag unit
package sacl_pkg;

    localparam int SETS       = 64;
    localparam int WAYS       = 4;
    localparam int LINE_BYTES = 64;

    localparam int ADDR_W = 48;

    // floor of log2, so that a line size that is not a power of two still works
    function automatic int flog2(input int value);
        int n;
        int x;
        n = 0;
        x = value;
        while (x > 1) begin
            x = x >> 1;
            n = n + 1;
        end
        return n;
    endfunction

    localparam int OFFSET_BITS = flog2(LINE_BYTES);
    localparam int BLOCK_W     = ADDR_W - OFFSET_BITS;
    localparam int SET_W       = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;

    localparam logic [SET_W-1:0] SET_MASK = SET_W'(SETS - 1);

    typedef logic [BLOCK_W-1:0] block_t;
    typedef logic [SET_W-1:0]   set_idx_t;
    typedef logic [WAY_W-1:0]   way_idx_t;

    typedef struct packed {
        logic   valid;
        logic   dirty;
        block_t tag;
    } way_entry_t;

    typedef way_entry_t [WAYS-1:0] tag_row_t;
    typedef way_idx_t [WAYS-1:0]   order_row_t;

    localparam int TAG_ROW_W   = $bits(tag_row_t);
    localparam int ORDER_ROW_W = $bits(order_row_t);

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              is_store;
    } request_t;

    typedef struct packed {
        logic              hit;
        logic              writeback;
        logic [ADDR_W-1:0] writeback_address;
        logic [ADDR_W-1:0] fill_address;
    } result_t;

    // recency order after reset: position j holds way WAYS-1-j
    function automatic order_row_t reset_order();
        order_row_t r;
        for (int j = 0; j < WAYS; j++) begin
            r[j] = way_idx_t'(WAYS - 1 - j);
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] line_address(input block_t blk);
        return {blk, {OFFSET_BITS{1'b0}}};
    endfunction

endpackage

/* src/sacl_ram.sv */
// generic single-write single-read synchronous ram with registered read data
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/sacl_lookup.sv */
// tag compare, victim choice, lru update and result formation for one set
module sacl_lookup import sacl_pkg::*; (
    input  tag_row_t   tag_row,
    input  order_row_t order_row,
    input  logic       row_ok,
    input  block_t     block,
    input  logic       is_store,
    output tag_row_t   tag_row_new,
    output order_row_t order_row_new,
    output result_t    result
);

    tag_row_t          row_eff;
    order_row_t        order_eff;
    logic [WAYS-1:0]   hit_vec;
    logic              hit_any;
    way_idx_t          hit_way;
    way_idx_t          victim;
    way_idx_t          use_way;
    way_idx_t          pos;
    logic              victim_dirty;

    always_comb begin
        row_eff   = tag_row;
        order_eff = row_ok ? order_row : reset_order();
        for (int k = 0; k < WAYS; k++) begin
            row_eff[k].valid = row_ok & tag_row[k].valid;
        end

        // parallel tag compare, lowest matching way wins
        hit_any = 1'b0;
        hit_way = '0;
        for (int k = WAYS - 1; k >= 0; k--) begin
            hit_vec[k] = row_eff[k].valid && (row_eff[k].tag == block);
            if (hit_vec[k]) begin
                hit_way = way_idx_t'(k);
            end
        end
        hit_any = |hit_vec;

        victim = order_eff[WAYS-1];
        if ({1'b0, victim} >= (WAY_W + 1)'(WAYS)) begin
            victim = '0;
        end

        use_way = hit_any ? hit_way : victim;

        // position of the used way in the order
        pos = way_idx_t'(WAYS - 1);
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (order_eff[i] == use_way) begin
                pos = way_idx_t'(i);
            end
        end

        for (int i = 0; i < WAYS; i++) begin
            if (i == 0) begin
                order_row_new[i] = use_way;
            end else if (way_idx_t'(i) <= pos) begin
                order_row_new[i] = order_eff[i-1];
            end else begin
                order_row_new[i] = order_eff[i];
            end
        end

        tag_row_new  = row_eff;
        victim_dirty = row_eff[victim].valid & row_eff[victim].dirty;
        result       = '0;
        if (hit_any) begin
            tag_row_new[hit_way].dirty = row_eff[hit_way].dirty | is_store;
            result.hit = 1'b1;
        end else begin
            tag_row_new[victim].valid = 1'b1;
            tag_row_new[victim].dirty = is_store;
            tag_row_new[victim].tag   = block;
            result.writeback         = victim_dirty;
            result.writeback_address = victim_dirty ? line_address(row_eff[victim].tag) : '0;
            result.fill_address      = line_address(block);
        end
    end

endmodule

/* src/set_assoc_cache_lru_writeback_unit.sv */
// top level: set-associative write-back cache tag unit with true lru replacement
//
// each request carries a byte address and a load/store flag and produces exactly one
// result: hit, a writeback flag with the line address of a dirty victim, and the line
// address to fill on a miss. tags and dirty/valid bits of a set sit in one row of a
// synchronous ram, the recency order of the set in a second ram. the accept cycle reads
// both rows; the lookup state then compares, picks the victim, updates the order and
// writes both rows back once the output register can take the result. the input is
// not ready in the lookup state, so a following request to the same set always reads
// the written row. no new request is taken until the current one is written back; a
// waiting result does not block the next accept, only its write-back step. per-set init
// flags make never-touched sets read as reset (all lines invalid, order from way WAYS-1
// down to way 0), so no clearing pass is needed after reset.
module set_assoc_cache_lru_writeback_unit import sacl_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  request_t s_payload,
    output logic     m_valid,
    input  logic     m_ready,
    output result_t  m_payload
);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_LOOKUP = 2'b10
    } state_t;

    state_t          state_reg, state_next;
    block_t          block_reg;
    logic            store_reg;
    set_idx_t        set_reg;
    logic            row_ok_reg;
    logic [SETS-1:0] row_init_reg;
    logic            m_valid_reg, m_valid_next;
    result_t         m_payload_reg;

    block_t          in_block;
    set_idx_t        in_set;
    logic            accept;
    logic            commit;

    tag_row_t        tag_rd, tag_wr;
    order_row_t      order_rd, order_wr;
    result_t         lookup_result;

    // block address and set index of the incoming request
    assign in_block = s_payload.address[ADDR_W-1:OFFSET_BITS];
    assign in_set   = in_block[SET_W-1:0] & SET_MASK;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid & s_ready;
    // write back only when the output register can take the result
    assign commit  = (state_reg == ST_LOOKUP) & (~m_valid_reg | m_ready);

    sacl_ram #(
        .WIDTH (TAG_ROW_W),
        .DEPTH (SETS)
    ) u_tag_ram (
        .aclk  (aclk),
        .we    (commit),
        .waddr (set_reg),
        .wdata (tag_wr),
        .re    (accept),
        .raddr (in_set),
        .rdata (tag_rd)
    );

    sacl_ram #(
        .WIDTH (ORDER_ROW_W),
        .DEPTH (SETS)
    ) u_order_ram (
        .aclk  (aclk),
        .we    (commit),
        .waddr (set_reg),
        .wdata (order_wr),
        .re    (accept),
        .raddr (in_set),
        .rdata (order_rd)
    );

    sacl_lookup u_lookup (
        .tag_row       (tag_rd),
        .order_row     (order_rd),
        .row_ok        (row_ok_reg),
        .block         (block_reg),
        .is_store      (store_reg),
        .tag_row_new   (tag_wr),
        .order_row_new (order_wr),
        .result        (lookup_result)
    );

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (commit) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            row_init_reg <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (commit) begin
                row_init_reg[set_reg] <= 1'b1;
            end
        end
    end

    // request capture and result register
    always_ff @(posedge aclk) begin
        if (accept) begin
            block_reg  <= in_block;
            store_reg  <= s_payload.is_store;
            set_reg    <= in_set;
            row_ok_reg <= row_init_reg[in_set];
        end
        if (commit) begin
            m_payload_reg <= lookup_result;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule
